FILE: sv/fss_pkg.sv
// fss_pkg: shared constants, types and helpers of the fuzzy subsequence scorer
// depends on nothing; used by every module of the block
`default_nettype none

package fss_pkg;

   // pattern store
   localparam int PATTERN_DEPTH = 256;
   localparam int PAT_AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

   // scoring
   localparam int SCORE_W = 17;
   localparam int GAIN_W = LEN_W + 2;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [GAIN_W-1:0] BOUNDARY_BONUS = GAIN_W'(5);
   localparam longint SCORE_BOUND_L = 64'(6 * PATTERN_DEPTH)
                                    + 64'(PATTERN_DEPTH) * 64'(PATTERN_DEPTH - 1);
   localparam logic [SCORE_W-1:0] SCORE_BOUND =
      (SCORE_BOUND_L > 64'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(SCORE_BOUND_L);

   // queues
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
   localparam int RESQ_DEPTH = 2;
   localparam int RESQ_AW = $clog2(RESQ_DEPTH);

   // opcodes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_CLEAR  = 2'd0;
   localparam opcode_type OP_APPEND = 2'd1;
   localparam opcode_type OP_TEXT   = 2'd2;
   localparam opcode_type OP_END    = 2'd3;

   // ascii codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;

   // classified command from the front end
   typedef struct packed {
      opcode_type op;
      logic [7:0] data_folded;
      logic       boundary;
   } cmd_type;

   typedef struct packed {
      logic               matched;
      logic [SCORE_W-1:0] score;
   } result_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_boundary(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_SLASH) || (c == CHAR_COLON) || (c == CHAR_DOT);
   endfunction

endpackage

`default_nettype wire

FILE: sv/fss_front.sv
// fss_front: takes request transactions, folds case, flags separators and
// queues the classified commands for the back end; uses fss_pkg
`default_nettype none

module fss_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [7:0]        req_data_byte,
   output logic                   cmd_valid,
   output fss_pkg::cmd_type       cmd_head,
   input  wire logic              cmd_take
);

   fss_pkg::cmd_type                entries_ff [fss_pkg::CMDQ_DEPTH];
   logic [fss_pkg::CMDQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [fss_pkg::CMDQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [fss_pkg::CMDQ_AW:0]       count_ff, count_in;
   fss_pkg::cmd_type                cmd_new;
   logic                            push_ok;
   logic                            pop_ok;

   // classify the incoming transaction
   always_comb begin
      cmd_new.op          = req_opcode;
      cmd_new.data_folded = fss_pkg::fold_case(req_data_byte);
      cmd_new.boundary    = fss_pkg::is_boundary(req_data_byte);
   end

   assign req_full  = (count_ff == (fss_pkg::CMDQ_AW+1)'(fss_pkg::CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = entries_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

FILE: sv/fss_back.sv
// fss_back: pattern memory and text scan engine, one command per cycle except while
// an end-of-text command waits on a full result queue; uses fss_pkg; feeds fss_result_queue
`default_nettype none

module fss_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire fss_pkg::cmd_type  cmd_head,
   output logic                   cmd_take,
   input  wire logic              res_full,
   output logic                   res_push,
   output fss_pkg::result_type    res_data
);

   logic [7:0]                   pat_mem [fss_pkg::PATTERN_DEPTH];
   logic [7:0]                   rd_data_ff;
   logic [fss_pkg::PAT_AW-1:0]   mem_raddr;
   logic [fss_pkg::LEN_W-1:0]    raddr_full;
   logic                         mem_we;

   logic [fss_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [fss_pkg::LEN_W-1:0]    pos_ff, pos_in;
   logic [fss_pkg::LEN_W-1:0]    run_ff, run_in;
   logic [fss_pkg::SCORE_W-1:0]  score_ff, score_in;
   logic                         bound_ff, bound_in;
   logic [7:0]                   head0_ff, head0_in;
   logic [7:0]                   cur_ff, cur_in;

   logic                         restart;
   logic                         scanning;
   logic [fss_pkg::GAIN_W-1:0]   gain;
   logic [fss_pkg::SCORE_W:0]    score_sum;

   assign cmd_take = cmd_valid && !((cmd_head.op == fss_pkg::OP_END) && res_full);
   assign scanning = (pos_ff < len_ff);

   always_comb begin
      gain = fss_pkg::GAIN_W'(1) + fss_pkg::GAIN_W'({run_ff, 1'b0});
      if (bound_ff) begin
         gain = gain + fss_pkg::BOUNDARY_BONUS;
      end
      score_sum = {1'b0, score_ff} + (fss_pkg::SCORE_W+1)'(gain);
   end

   always_comb begin
      len_in   = len_ff;
      pos_in   = pos_ff;
      run_in   = run_ff;
      score_in = score_ff;
      bound_in = bound_ff;
      head0_in = head0_ff;
      cur_in   = cur_ff;
      mem_we   = 1'b0;
      restart  = 1'b0;
      res_push = 1'b0;
      if (cmd_take) begin
         unique case (cmd_head.op)
            fss_pkg::OP_CLEAR: begin
               len_in  = '0;
               restart = 1'b1;
            end
            fss_pkg::OP_APPEND: begin
               if (len_ff < fss_pkg::LEN_W'(fss_pkg::PATTERN_DEPTH)) begin
                  mem_we = 1'b1;
                  len_in = len_ff + 1'b1;
                  if (len_ff == '0) begin
                     head0_in = cmd_head.data_folded;
                  end
               end
               restart = 1'b1;
            end
            fss_pkg::OP_TEXT: begin
               if (scanning) begin
                  bound_in = cmd_head.boundary;
                  if (cmd_head.data_folded == cur_ff) begin
                     score_in = score_sum[fss_pkg::SCORE_W] ? fss_pkg::SCORE_MAX
                                                            : score_sum[fss_pkg::SCORE_W-1:0];
                     run_in = run_ff + 1'b1;
                     pos_in = pos_ff + 1'b1;
                     cur_in = rd_data_ff;
                  end else begin
                     run_in = '0;
                  end
               end
            end
            fss_pkg::OP_END: begin
               res_push = 1'b1;
               restart  = 1'b1;
            end
            default: ;
         endcase
      end
      if (restart) begin
         pos_in   = '0;
         run_in   = '0;
         score_in = '0;
         bound_in = 1'b1;
         cur_in   = head0_in;
      end
   end

   // read one entry ahead so a match can advance every cycle
   assign raddr_full = pos_in + 1'b1;
   assign mem_raddr  = raddr_full[fss_pkg::PAT_AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pat_mem[len_ff[fss_pkg::PAT_AW-1:0]] <= cmd_head.data_folded;
      end
      if (mem_we && (len_ff[fss_pkg::PAT_AW-1:0] == mem_raddr)) begin
         rd_data_ff <= cmd_head.data_folded;
      end else begin
         rd_data_ff <= pat_mem[mem_raddr];
      end
   end

   always_comb begin
      res_data.matched = !scanning;
      res_data.score   = scanning ? '0 : score_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         pos_ff   <= '0;
         run_ff   <= '0;
         score_ff <= '0;
         bound_ff <= 1'b1;
      end else begin
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         run_ff   <= run_in;
         score_ff <= score_in;
         bound_ff <= bound_in;
      end
   end

   always_ff @(posedge clock) begin
      head0_ff <= head0_in;
      cur_ff   <= cur_in;
   end

endmodule

`default_nettype wire

FILE: sv/fss_result_queue.sv
// fss_result_queue: small result queue between the scan engine and the
// response side; uses fss_pkg
`default_nettype none

module fss_result_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire fss_pkg::result_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output fss_pkg::result_type       head
);

   fss_pkg::result_type           entries_ff [fss_pkg::RESQ_DEPTH];
   logic [fss_pkg::RESQ_AW-1:0]   wr_ptr_ff;
   logic [fss_pkg::RESQ_AW-1:0]   rd_ptr_ff;
   logic [fss_pkg::RESQ_AW:0]     count_ff, count_in;
   logic                          push_ok;
   logic                          pop_ok;

   assign full    = (count_ff == (fss_pkg::RESQ_AW+1)'(fss_pkg::RESQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/fuzzy_subsequence_scorer_unit.sv
// fuzzy_subsequence_scorer_unit: top level of the fuzzy subsequence scorer
// instantiates fss_front, fss_back and fss_result_queue; uses fss_pkg
//
// Scores a stored pattern against a stream of text as a case-insensitive
// (ASCII only) subsequence match. Each request transaction carries an opcode:
// clear pattern, append pattern byte (dropped once 256 bytes are stored),
// text byte, or end of text. Every pattern change also restarts the text scan.
// A matched text byte scores 1 plus twice the run of directly preceding
// matches, plus 5 at text start or after space, slash, colon or dot; any
// unmatched byte ends the run and text after a full match is ignored. Only end
// of text produces a response transaction: the match flag and the score (0 if
// not matched; an empty pattern counts as matched with score 0). The block
// takes one request per clock while req_full is low; the scan engine compares
// one text byte per cycle against a pattern byte prefetched from the pattern
// memory one entry ahead, so a match can advance the pattern position every
// cycle. A request reaches the engine through a 4-entry command queue, and
// an end-of-text request is registered in that queue and its response in the
// result queue before the response is on the response ports. Responses wait
// in a 2-entry queue; when that queue is full, end-of-text requests hold in the
// command queue and full rises once it fills. No clearing pass after reset.
`default_nettype none

module fuzzy_subsequence_scorer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request side
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [7:0]                    req_data_byte,
   // response side
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic                               rsp_matched,
   output logic [fss_pkg::SCORE_W-1:0]        rsp_score
);

   // front to back command path
   logic                  cmd_valid;
   fss_pkg::cmd_type      cmd_head;
   logic                  cmd_take;

   // back to result queue path
   logic                  res_full;
   logic                  res_push;
   fss_pkg::result_type   res_data;
   fss_pkg::result_type   rsp_head;

   // front: classify requests and queue them
   fss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .cmd_valid     (cmd_valid),
      .cmd_head      (cmd_head),
      .cmd_take      (cmd_take)
   );

   // back: pattern memory and scan state
   fss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // responses wait here until popped
   fss_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_matched = rsp_head.matched;
   assign rsp_score   = rsp_head.score;

endmodule

`default_nettype wire

FILE: sv/fss_checker.sv
// fss_checker: port-level checks of fuzzy_subsequence_scorer_unit, with bind
// uses fss_pkg
`default_nettype none

module fss_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_push,
   input wire logic                        req_full,
   input wire logic [1:0]                  req_opcode,
   input wire logic [7:0]                  req_data_byte,
   input wire logic                        rsp_empty,
   input wire logic                        rsp_pop,
   input wire logic                        rsp_matched,
   input wire logic [fss_pkg::SCORE_W-1:0] rsp_score
);

   // a miss never reports a score
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_matched) |-> (rsp_score == '0))
      else $error("unmatched response with nonzero score");

   // score cannot exceed the full-pattern maximum
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_score <= fss_pkg::SCORE_BOUND))
      else $error("score above reachable maximum");

   // a waiting response holds until popped
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_score) && $stable(rsp_matched)))
      else $error("pending response changed or vanished");

   // reset leaves the result queue empty and the command queue not full
   assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

bind fuzzy_subsequence_scorer_unit fss_checker u_checker (.*);

`default_nettype wire
